@@ design/hduart_pkg.sv @@
// Shared types and codes for the half-duplex 8N1 UART bit engine.
package hduart_pkg;

  localparam int unsigned DataWidth   = 8;
  localparam int unsigned CountWidth  = 16;
  localparam int unsigned BitCntWidth = 4;
  localparam int unsigned ApbAddrWidth = 3;
  localparam int unsigned ApbDataWidth = 32;

  localparam logic [CountWidth-1:0]  LimitReset = 16'd128;
  localparam logic [BitCntWidth-1:0] FrameLoad  = 4'd10;
  localparam logic [BitCntWidth-1:0] LastData   = 4'd9;
  localparam logic [DataWidth-1:0]   FillOnes   = 8'hFF;

  // Word index of the receive limit register on the configuration port.
  localparam logic RegReceiveLimit = 1'b0;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_SEND     = 3'd1,
    CMD_RX_MODE  = 3'd2,
    CMD_TX_MODE  = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    SEL_HUNT  = 3'd0,
    SEL_FIRST = 3'd1,
    SEL_FULL  = 3'd2,
    SEL_START = 3'd3,
    SEL_KEEP  = 3'd4
  } reload_sel_t;

  typedef struct packed {
    logic [2:0]           cmd;
    logic                 rx_line;
    logic [DataWidth-1:0] send_byte;
  } item_t;

  typedef struct packed {
    logic                  tx_line;
    logic                  rx_valid;
    logic [DataWidth-1:0]  rx_byte;
    logic                  rx_overflow;
    logic                  send_accepted;
    logic                  tx_idle;
    logic                  rx_enabled;
    logic                  tx_enabled;
    logic [2:0]            reload_select;
    logic [CountWidth-1:0] received_count;
  } result_t;

endpackage

@@ design/hduart_if.sv @@
// Valid/ready channel interfaces for UART events and UART results.
interface hduart_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic       rx_line;
  logic [7:0] send_byte;

  modport source (output valid, output cmd, output rx_line, output send_byte, input ready);
  modport sink (input valid, input cmd, input rx_line, input send_byte, output ready);
endinterface

interface hduart_result_if;
  logic        valid;
  logic        ready;
  logic        tx_line;
  logic        rx_valid;
  logic [7:0]  rx_byte;
  logic        rx_overflow;
  logic        send_accepted;
  logic        tx_idle;
  logic        rx_enabled;
  logic        tx_enabled;
  logic [2:0]  reload_select;
  logic [15:0] received_count;

  modport source (
    output valid, output tx_line, output rx_valid, output rx_byte, output rx_overflow,
    output send_accepted, output tx_idle, output rx_enabled, output tx_enabled,
    output reload_select, output received_count, input ready
  );
  modport sink (
    input valid, input tx_line, input rx_valid, input rx_byte, input rx_overflow,
    input send_accepted, input tx_idle, input rx_enabled, input tx_enabled,
    input reload_select, input received_count, output ready
  );
endinterface

@@ design/hduart_cfg.sv @@
// APB register block holding the receive limit.
module hduart_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hduart_pkg::ApbAddrWidth-1:0] paddr,
  input  logic [hduart_pkg::ApbDataWidth-1:0] pwdata,
  output logic [hduart_pkg::ApbDataWidth-1:0] prdata,
  output logic                                pready,
  output logic [hduart_pkg::CountWidth-1:0]   receive_limit
);
  import hduart_pkg::*;

  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ApbAddrWidth-1] == RegReceiveLimit);

  always_ff @(posedge clk) begin
    if (rst) begin
      receive_limit <= LimitReset;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      receive_limit <= pwdata[CountWidth-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(ApbDataWidth-CountWidth){1'b0}}, receive_limit};
    end
  end

endmodule

@@ design/hduart_core.sv @@
// UART bit engine state and the single-pass step logic for one event.
module hduart_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  hduart_pkg::item_t                 item,
  input  logic [hduart_pkg::CountWidth-1:0] receive_limit,
  output hduart_pkg::result_t               result
);
  import hduart_pkg::*;

  logic [DataWidth-1:0]   shift_reg, shift_reg_next;
  logic [BitCntWidth-1:0] bit_counter, bit_counter_next;
  logic                   receive_on, receive_on_next;
  logic                   transmit_on, transmit_on_next;
  logic                   send_done, send_done_next;
  logic                   tx_level, tx_level_next;
  logic [CountWidth-1:0]  stored_count, stored_count_next;

  logic [BitCntWidth-1:0] cnt_inc;
  logic [BitCntWidth-1:0] cnt_dec;
  logic [DataWidth-1:0]   rx_shifted;
  logic [DataWidth-1:0]   tx_src;

  always_comb begin
    shift_reg_next    = shift_reg;
    bit_counter_next  = bit_counter;
    receive_on_next   = receive_on;
    transmit_on_next  = transmit_on;
    send_done_next    = send_done;
    tx_level_next     = tx_level;
    stored_count_next = stored_count;

    cnt_inc    = bit_counter + 1'b1;
    cnt_dec    = bit_counter - 1'b1;
    rx_shifted = {item.rx_line, shift_reg[DataWidth-1:1]};
    tx_src     = (cnt_dec > LastData) ? FillOnes : shift_reg;

    result               = '0;
    result.reload_select = SEL_KEEP;

    case (item.cmd)
      CMD_TICK: begin
        if (item.rx_line && (bit_counter == '0)) begin
          result.reload_select = SEL_HUNT;
        end else if (receive_on) begin
          if (bit_counter == '0) begin
            // Line is low here, so this is the start bit.
            result.reload_select = SEL_FIRST;
            bit_counter_next     = BitCntWidth'(1);
            shift_reg_next       = '0;
          end else if ((cnt_inc >= BitCntWidth'(2)) && (cnt_inc <= LastData)) begin
            result.reload_select = SEL_FULL;
            bit_counter_next     = cnt_inc;
            shift_reg_next       = rx_shifted;
            if (cnt_inc == LastData) begin
              if (stored_count < receive_limit) begin
                result.rx_valid   = 1'b1;
                result.rx_byte    = rx_shifted;
                stored_count_next = stored_count + 1'b1;
              end else begin
                receive_on_next    = 1'b0;
                result.rx_overflow = 1'b1;
              end
            end
          end else begin
            // Stop bit (or a wrapped count) ends the frame.
            result.reload_select = SEL_HUNT;
            bit_counter_next     = '0;
          end
        end else if (transmit_on) begin
          result.reload_select = SEL_FULL;
          // An underflowing count recovers to the last data position with ones loaded.
          bit_counter_next = (cnt_dec > LastData) ? LastData : cnt_dec;
          if (bit_counter_next > BitCntWidth'(1)) begin
            tx_level_next  = tx_src[0];
            shift_reg_next = tx_src >> 1;
          end else begin
            tx_level_next  = 1'b1;
            shift_reg_next = tx_src;
            if (bit_counter_next == '0) begin
              send_done_next = 1'b1;
            end
          end
        end
      end
      CMD_SEND: begin
        if (send_done) begin
          result.send_accepted = 1'b1;
          result.reload_select = SEL_START;
          tx_level_next        = 1'b0;
          shift_reg_next       = item.send_byte;
          bit_counter_next     = FrameLoad;
          send_done_next       = 1'b0;
        end
      end
      CMD_RX_MODE: begin
        receive_on_next      = 1'b1;
        transmit_on_next     = 1'b0;
        bit_counter_next     = '0;
        result.reload_select = SEL_HUNT;
      end
      CMD_TX_MODE: begin
        transmit_on_next = 1'b1;
        receive_on_next  = 1'b0;
        bit_counter_next = '0;
        send_done_next   = 1'b1;
      end
      CMD_CLEAR: begin
        stored_count_next = '0;
      end
      default: begin
      end
    endcase

    result.tx_line        = tx_level_next;
    result.tx_idle        = send_done_next;
    result.rx_enabled     = receive_on_next;
    result.tx_enabled     = transmit_on_next;
    result.received_count = stored_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_reg    <= '0;
      bit_counter  <= '0;
      receive_on   <= 1'b0;
      transmit_on  <= 1'b0;
      send_done    <= 1'b0;
      tx_level     <= 1'b1;
      stored_count <= '0;
    end else if (step) begin
      shift_reg    <= shift_reg_next;
      bit_counter  <= bit_counter_next;
      receive_on   <= receive_on_next;
      transmit_on  <= transmit_on_next;
      send_done    <= send_done_next;
      tx_level     <= tx_level_next;
      stored_count <= stored_count_next;
    end
  end

endmodule

@@ design/half_duplex_uart_8n1.sv @@
// Half-duplex 8N1 UART bit engine: event register, step logic and result register.
//
// Usage: each transfer on the events channel carries one command (timer tick with the
// sampled receive level, send byte, enter receive mode, enter transmit mode, clear the
// received count). Every event produces exactly one transfer on the results channel,
// in order, carrying the transmit line level, any received byte or overflow, the send
// acknowledge, mode flags, the timer reload select and the received byte count.
// An accepted event is held in the event register; the step logic then updates the
// engine state and loads the result register, from which the result is transferred.
// Throughput is one event per cycle; both registers advance together whenever the
// result register is empty or being read, so a full pipeline keeps accepting while
// results are taken every cycle.
// When the results sink stalls, the result register holds, the event register fills,
// and events.ready drops; nothing is lost or repeated.
// Reset clears the engine state (transmit line high, both modes off, count zero),
// empties both registers and sets the receive limit to 128. The user must write
// the limit over the APB port while no event is in flight; the block does not enforce it.
module half_duplex_uart_8n1 (
  input  logic                                clk,
  input  logic                                rst,
  hduart_event_if.sink                        events,
  hduart_result_if.source                     results,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hduart_pkg::ApbAddrWidth-1:0] paddr,
  input  logic [hduart_pkg::ApbDataWidth-1:0] pwdata,
  output logic [hduart_pkg::ApbDataWidth-1:0] prdata,
  output logic                                pready
);
  import hduart_pkg::*;

  logic                  ev_valid;
  item_t                 ev_item;
  logic                  res_valid;
  result_t               res_data;
  result_t               step_result;
  logic                  advance;
  logic [CountWidth-1:0] receive_limit;

  hduart_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .receive_limit (receive_limit)
  );

  // The event in the register steps the engine when the result register can take it.
  assign advance      = ev_valid && (!res_valid || results.ready);
  assign events.ready = !ev_valid || advance;

  hduart_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .item          (ev_item),
    .receive_limit (receive_limit),
    .result        (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (events.valid && events.ready) begin
        ev_valid <= 1'b1;
      end else if (advance) begin
        ev_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (events.valid && events.ready) begin
      ev_item <= '{cmd: events.cmd, rx_line: events.rx_line, send_byte: events.send_byte};
    end
    if (advance) begin
      res_data <= step_result;
    end
  end

  assign results.valid          = res_valid;
  assign results.tx_line        = res_data.tx_line;
  assign results.rx_valid       = res_data.rx_valid;
  assign results.rx_byte        = res_data.rx_byte;
  assign results.rx_overflow    = res_data.rx_overflow;
  assign results.send_accepted  = res_data.send_accepted;
  assign results.tx_idle        = res_data.tx_idle;
  assign results.rx_enabled     = res_data.rx_enabled;
  assign results.tx_enabled     = res_data.tx_enabled;
  assign results.reload_select  = res_data.reload_select;
  assign results.received_count = res_data.received_count;

endmodule

@@ bench/hduart_step_checker.sv @@
// Checker for the UART bit engine: mirrors the engine state and compares every result transfer.
module hduart_step_checker
  import hduart_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  hduart_event_if                 ev,
  hduart_result_if                res,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic                    pready,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output int                      mismatches,
  output int                      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Mirror of the engine state and of the receive limit register.
  logic [DataWidth-1:0]   shift_q;
  logic [BitCntWidth-1:0] bits_q;
  logic                   rx_on;
  logic                   tx_on;
  logic                   sent_all;
  logic                   line_level;
  logic [CountWidth-1:0]  stored;
  logic [CountWidth-1:0]  limit_q;

  result_t results_due[$];
  result_t got_r;
  result_t want_r;
  item_t   step_in;
  int      results_seen;

  function automatic result_t advance_engine(item_t it);
    result_t r;
    r = '0;
    r.reload_select = SEL_KEEP;
    case (it.cmd)
      CMD_TICK: begin
        if (it.rx_line && bits_q == 0) begin
          r.reload_select = SEL_HUNT;
        end else if (rx_on) begin
          if (bits_q == 0) begin
            // Line is low with no frame running: start bit.
            r.reload_select = SEL_FIRST;
            bits_q = BitCntWidth'(1);
            shift_q = '0;
          end else begin
            r.reload_select = SEL_FULL;
            bits_q = bits_q + 1'b1;
            if (bits_q >= 2 && bits_q <= LastData) begin
              shift_q = {it.rx_line, shift_q[DataWidth-1:1]};
              if (bits_q == LastData) begin
                if (stored < limit_q) begin
                  r.rx_valid = 1'b1;
                  r.rx_byte = shift_q;
                  stored = stored + 1'b1;
                end else begin
                  rx_on = 1'b0;
                  r.rx_overflow = 1'b1;
                end
              end
            end else begin
              // At the stop bit (or a wrapped count) the frame ends without a check.
              bits_q = '0;
              r.reload_select = SEL_HUNT;
            end
          end
        end else if (tx_on) begin
          r.reload_select = SEL_FULL;
          bits_q = bits_q - 1'b1;
          if (bits_q > LastData) begin
            // A wrapped count sends ones until it runs down again.
            bits_q = LastData;
            shift_q = FillOnes;
          end
          if (bits_q > 1) begin
            line_level = shift_q[0];
            shift_q = shift_q >> 1;
          end else begin
            line_level = 1'b1;
            if (bits_q == 0) sent_all = 1'b1;
          end
        end
      end
      CMD_SEND: begin
        if (sent_all) begin
          r.send_accepted = 1'b1;
          line_level = 1'b0;
          shift_q = it.send_byte;
          bits_q = FrameLoad;
          sent_all = 1'b0;
          r.reload_select = SEL_START;
        end
      end
      CMD_RX_MODE: begin
        rx_on = 1'b1;
        tx_on = 1'b0;
        bits_q = '0;
        r.reload_select = SEL_HUNT;
      end
      CMD_TX_MODE: begin
        tx_on = 1'b1;
        rx_on = 1'b0;
        bits_q = '0;
        sent_all = 1'b1;
      end
      CMD_CLEAR: begin
        stored = '0;
      end
      default: begin
      end
    endcase
    r.tx_line = line_level;
    r.tx_idle = sent_all;
    r.rx_enabled = rx_on;
    r.tx_enabled = tx_on;
    r.received_count = stored;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic compare_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                results_seen, name, got, want));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shift_q = '0;
      bits_q = '0;
      rx_on = 1'b0;
      tx_on = 1'b0;
      sent_all = 1'b0;
      line_level = 1'b1;
      stored = '0;
      limit_q = LimitReset;
      results_due.delete();
      mismatches = 0;
      outstanding = 0;
      results_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[ApbAddrWidth-1:2] == RegReceiveLimit) begin
        limit_q = pwdata[CountWidth-1:0];
      end
      if (ev.valid && ev.ready) begin
        step_in = {ev.cmd, ev.rx_line, ev.send_byte};
        results_due.push_back(advance_engine(step_in));
      end
      if (res.valid && res.ready) begin
        got_r = {res.tx_line, res.rx_valid, res.rx_byte, res.rx_overflow, res.send_accepted,
                 res.tx_idle, res.rx_enabled, res.tx_enabled, res.reload_select,
                 res.received_count};
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want_r = results_due.pop_front();
          compare_field("tx_line", got_r.tx_line, want_r.tx_line);
          compare_field("rx_valid", got_r.rx_valid, want_r.rx_valid);
          compare_field("rx_byte", got_r.rx_byte, want_r.rx_byte);
          compare_field("rx_overflow", got_r.rx_overflow, want_r.rx_overflow);
          compare_field("send_accepted", got_r.send_accepted, want_r.send_accepted);
          compare_field("tx_idle", got_r.tx_idle, want_r.tx_idle);
          compare_field("rx_enabled", got_r.rx_enabled, want_r.rx_enabled);
          compare_field("tx_enabled", got_r.tx_enabled, want_r.tx_enabled);
          compare_field("reload_select", got_r.reload_select, want_r.reload_select);
          compare_field("received_count", got_r.received_count, want_r.received_count);
        end
        results_seen++;
      end
      outstanding = results_due.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the UART bit engine bench: clock, reset, event stimulus, result sink and verdict.
module tb_top;
  import hduart_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RunLimit = 500000;
  localparam int PhaseItems = 200;
  localparam int NumPhases = 6;
  localparam int HoldPhase = 2;
  localparam int LongHoldCycles = 400;
  localparam logic [2:0] CmdUnusedFirst = 3'd5;
  localparam logic [2:0] CmdUnusedLast = 3'd7;
  localparam logic [ApbAddrWidth-1:0] LimitAddr = {RegReceiveLimit, 2'b00};

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ApbAddrWidth-1:0] paddr;
  logic [ApbDataWidth-1:0] pwdata;
  logic [ApbDataWidth-1:0] prdata;
  logic                    pready;

  int mismatch_count;
  int results_owed;
  int events_offered = 0;
  int results_taken = 0;
  int results_hold_cycles = 0;
  int cycles_run;
  bit src_burst = 1'b0;
  bit snk_burst = 1'b0;

  hduart_event_if  ev_ch ();
  hduart_result_if res_ch ();

  half_duplex_uart_8n1 dut (
    .clk     (clk),
    .rst     (rst),
    .events  (ev_ch),
    .results (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  hduart_step_checker step_chk (
    .clk         (clk),
    .rst         (rst),
    .ev          (ev_ch),
    .res         (res_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatch_count),
    .outstanding (results_owed)
  );

  always #5 clk = ~clk;

  // Offers one event and returns right after the edge that takes it.
  task automatic offer(logic [2:0] cmd, logic rx, logic [DataWidth-1:0] data);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      ev_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_ch.valid <= 1'b1;
    ev_ch.cmd <= cmd;
    ev_ch.rx_line <= rx;
    ev_ch.send_byte <= data;
    do @(posedge clk); while (!ev_ch.ready);
    events_offered++;
  endtask

  // Stops offering and waits until every expected result has been taken.
  task automatic settle();
    ev_ch.valid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_limit(logic [CountWidth-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LimitAddr;
    pwdata <= ApbDataWidth'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Start bit, data bits and stop bit; now and then the frame is cut short.
  task automatic receive_frame();
    int data_bits;
    data_bits = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : 8;
    if ($urandom_range(0, 9) < 7) offer(CMD_RX_MODE, 1'($urandom), 8'($urandom));
    offer(CMD_TICK, 1'b0, 8'($urandom));
    repeat (data_bits) offer(CMD_TICK, 1'($urandom), 8'($urandom));
    offer(CMD_TICK, 1'($urandom), 8'($urandom));
    repeat ($urandom_range(0, 2)) offer(CMD_TICK, 1'b1, 8'($urandom));
  endtask

  task automatic transmit_frame();
    if ($urandom_range(0, 9) < 7) offer(CMD_TX_MODE, 1'($urandom), 8'($urandom));
    offer(CMD_SEND, 1'($urandom), 8'($urandom));
    for (int i = 0; i < 10; i++) begin
      offer(CMD_TICK, 1'($urandom), 8'($urandom));
      if ($urandom_range(0, 15) == 0) offer(CMD_SEND, 1'($urandom), 8'($urandom));
    end
    // Extra ticks, with a random line level, run the bit count past zero.
    repeat ($urandom_range(0, 2)) offer(CMD_TICK, 1'($urandom), 8'($urandom));
  endtask

  task automatic scramble();
    logic [2:0] cmd;
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 29) == 0) cmd = 3'($urandom_range(CmdUnusedFirst, CmdUnusedLast));
      else cmd = 3'($urandom_range(CMD_TICK, CMD_CLEAR));
      offer(cmd, 1'($urandom), 8'($urandom));
    end
  endtask

  // Result sink; a requested long hold lets the block fill and stall its input.
  initial begin
    int gap;
    res_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (results_hold_cycles > 0) begin
        gap = results_hold_cycles;
        results_hold_cycles = 0;
      end else begin
        gap = snk_burst ? 0 : $urandom_range(0, 15);
      end
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      results_taken++;
      if (results_taken % 48 == 0) snk_burst = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    cycles_run = 0;
    while (cycles_run < RunLimit) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [CountWidth-1:0] phase_limits [NumPhases];
    int phase_start;
    int pick;
    phase_limits = '{16'd2, 16'd0, 16'd65535, 16'd1, 16'd5, LimitReset};
    phase_limits[4] = 16'($urandom_range(3, 8));
    rst <= 1'b1;
    ev_ch.valid <= 1'b0;
    ev_ch.cmd <= CMD_TICK;
    ev_ch.rx_line <= 1'b1;
    ev_ch.send_byte <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: unused codes, idle and modeless ticks, rejected sends, a full
    // transmit frame with a wrapped count, and a send taken in receive mode.
    for (int c = CmdUnusedFirst; c <= CmdUnusedLast; c++) offer(3'(c), 1'b1, 8'hFF);
    offer(CMD_TICK, 1'b1, 8'h00);
    offer(CMD_TICK, 1'b0, 8'h00);
    offer(CMD_SEND, 1'b1, 8'hFF);
    offer(CMD_CLEAR, 1'b0, 8'h00);
    offer(CMD_TX_MODE, 1'b0, 8'h00);
    offer(CMD_SEND, 1'b0, 8'h00);
    offer(CMD_SEND, 1'b1, 8'hFF);
    repeat (11) offer(CMD_TICK, 1'b0, 8'h00);
    offer(CMD_RX_MODE, 1'b0, 8'h00);
    offer(CMD_SEND, 1'b0, 8'hFF);
    offer(CMD_TICK, 1'b0, 8'h00);

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      write_limit(phase_limits[p]);
      if (p == HoldPhase) results_hold_cycles = LongHoldCycles;
      phase_start = events_offered;
      while (events_offered - phase_start < PhaseItems) begin
        src_burst = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 9);
        if (pick < 4) receive_frame();
        else if (pick < 7) transmit_frame();
        else if (pick < 9) scramble();
        else offer(CMD_CLEAR, 1'($urandom), 8'($urandom));
      end
    end

    settle();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ half_duplex_uart_8n1.f @@
design/hduart_pkg.sv
design/hduart_if.sv
design/hduart_cfg.sv
design/hduart_core.sv
design/half_duplex_uart_8n1.sv
bench/hduart_step_checker.sv
bench/tb_top.sv
